@@ src/dtpb_pkg.sv @@
// Shared types, constants and rounding helper for the depth-to-point back-projection core.
`default_nettype none

package dtpb_pkg;

    // Default image limits
    localparam int unsigned MAX_WIDTH_DEF  = 4096;
    localparam int unsigned MAX_HEIGHT_DEF = 4096;

    // Field widths
    localparam int unsigned DEPTH_W    = 16;
    localparam int unsigned COORD_W    = 24;
    localparam int unsigned Z_W        = 20;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 72;
    localparam int unsigned PROD1_W    = 32;
    localparam int unsigned PROD2_W    = 56;

    // Saturation limits and rounding constant (Q24 product)
    localparam logic [32:0] POS_LIMIT  = 33'd8388607;
    localparam logic [32:0] NEG_LIMIT  = 33'd8388608;
    localparam logic [56:0] ROUND_HALF = 57'd8388608;

    // Register reset values
    localparam logic [15:0] RST_MIN_DEPTH   = 16'd300;
    localparam logic [15:0] RST_MAX_DEPTH   = 16'd5000;
    localparam logic [7:0]  RST_STRIDE      = 8'd2;
    localparam logic [12:0] RST_IMAGE_WIDTH = 13'd640;
    localparam logic [15:0] RST_CENTER_X    = 16'd5120;
    localparam logic [15:0] RST_CENTER_Y    = 16'd3840;
    localparam logic [23:0] RST_INV_FOCAL_X = 24'd43690;
    localparam logic [23:0] RST_INV_FOCAL_Y = 24'd43690;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DEPTH,
        CFG_MAX_DEPTH,
        CFG_STRIDE,
        CFG_IMAGE_WIDTH,
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_INV_FOCAL_X,
        CFG_INV_FOCAL_Y
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] min_depth_mm;
        logic [15:0] max_depth_mm;
        logic [7:0]  stride;
        logic [12:0] image_width;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [23:0] inv_focal_x;
        logic [23:0] inv_focal_y;
    } t_cfg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_DEPTH,
        ST_MUL_FOCAL,
        ST_ROUND
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic mul_depth_en;
        logic mul_focal_en;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic has_result;
        logic out_free;
    } t_dp_status;

    // Round half away from zero, shift by 24, apply sign, saturate to 24 bits
    function automatic logic [COORD_W-1:0] round_sat(input logic [PROD2_W-1:0] prod,
                                                     input logic neg);
        logic [56:0]        sum;
        logic [32:0]        mag;
        logic [COORD_W-1:0] res;
        sum = {1'b0, prod} + ROUND_HALF;
        mag = sum[56:24];
        if (neg) begin
            if (mag > NEG_LIMIT) res = 24'h800000;
            else                 res = 24'd0 - mag[23:0];
        end else begin
            if (mag > POS_LIMIT) res = 24'h7FFFFF;
            else                 res = mag[23:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ src/depth_to_point_backprojection_core.sv @@
// Top level of the depth image to point back-projection core.
// Takes one 16-bit depth pixel (mm) per item in raster order, tracks column and row itself,
// keeps pixels on the stride grid with nonzero depth in [min, max], and back-projects each
// kept pixel through the pinhole model into x, y, z in 1/16 mm (x, y rounded and saturated).
// A frame's last pixel always yields a result with tlast set; a non-kept one carries zeros.
// A dropped pixel ends at accept; a kept or frame-end pixel then takes the two registered
// multiply stages (depth, focal) and rounds into the output register once that is free.
// The output register lets the next pixel enter while a result waits.
`default_nettype none

module depth_to_point_backprojection_core #(
    parameter int unsigned MAX_WIDTH  = dtpb_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = dtpb_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Input pixel stream
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [dtpb_pkg::IN_TDATA_W-1:0]       s_axis_tdata,   // [15:0] depth_mm
    input  wire logic                                  s_axis_tuser,   // frame_start
    input  wire logic                                  s_axis_tlast,   // frame_end
    // Output point stream
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic [dtpb_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,   // [23:0] point_x,
                                                                       // [47:24] point_y,
                                                                       // [67:48] point_z,
                                                                       // [71:68] zero
    output logic                                       m_axis_tuser,   // point_valid
    output logic                                       m_axis_tlast,   // frame_done
    // Configuration write port
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [dtpb_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [dtpb_pkg::CFG_DATA_W-1:0]       i_cfg_wr_data
);
    import dtpb_pkg::*;

    t_cfg               cfg;
    t_dp_cmd            cmd;
    t_dp_status         status;
    logic [COORD_W-1:0] point_x, point_y;
    logic [Z_W-1:0]     point_z;

    dtpb_cfg_regs u_cfg_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cfg         (cfg)
    );

    dtpb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dtpb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_depth_mm    (s_axis_tdata[15:0]),
        .i_frame_start (s_axis_tuser),
        .i_frame_end   (s_axis_tlast),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_point_x     (point_x),
        .o_point_y     (point_y),
        .o_point_z     (point_z),
        .o_point_valid (m_axis_tuser),
        .o_frame_done  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, point_z, point_y, point_x};

endmodule

`default_nettype wire

@@ src/dtpb_cfg_regs.sv @@
// Configuration register bank written through a plain index/data write port.
`default_nettype none

module dtpb_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [dtpb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [dtpb_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data,
    output dtpb_pkg::t_cfg                          o_cfg
);
    import dtpb_pkg::*;

    t_cfg r_cfg;

    // Register writes, decoded by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_depth_mm <= RST_MIN_DEPTH;
            r_cfg.max_depth_mm <= RST_MAX_DEPTH;
            r_cfg.stride       <= RST_STRIDE;
            r_cfg.image_width  <= RST_IMAGE_WIDTH;
            r_cfg.center_x     <= RST_CENTER_X;
            r_cfg.center_y     <= RST_CENTER_Y;
            r_cfg.inv_focal_x  <= RST_INV_FOCAL_X;
            r_cfg.inv_focal_y  <= RST_INV_FOCAL_Y;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MIN_DEPTH:   r_cfg.min_depth_mm <= i_cfg_wr_data[15:0];
                CFG_MAX_DEPTH:   r_cfg.max_depth_mm <= i_cfg_wr_data[15:0];
                CFG_STRIDE:      r_cfg.stride       <= i_cfg_wr_data[7:0];
                CFG_IMAGE_WIDTH: r_cfg.image_width  <= i_cfg_wr_data[12:0];
                CFG_CENTER_X:    r_cfg.center_x     <= i_cfg_wr_data[15:0];
                CFG_CENTER_Y:    r_cfg.center_y     <= i_cfg_wr_data[15:0];
                CFG_INV_FOCAL_X: r_cfg.inv_focal_x  <= i_cfg_wr_data;
                CFG_INV_FOCAL_Y: r_cfg.inv_focal_y  <= i_cfg_wr_data;
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ src/dtpb_ctrl.sv @@
// Sequencer for one pixel: accept, depth multiply, focal multiply, round into output register.
`default_nettype none

module dtpb_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  dtpb_pkg::t_dp_status    i_status,
    output dtpb_pkg::t_dp_cmd       o_cmd
);
    import dtpb_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    // dropped pixels finish here; others run the multiply chain
                    if (i_status.has_result) n_state = ST_MUL_DEPTH;
                end
            end
            ST_MUL_DEPTH: begin
                o_cmd.mul_depth_en = 1'b1;
                n_state = ST_MUL_FOCAL;
            end
            ST_MUL_FOCAL: begin
                o_cmd.mul_focal_en = 1'b1;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ src/dtpb_datapath.sv @@
// Pixel position tracking, keep test, two-stage multiply, rounding and output register.
`default_nettype none

module dtpb_datapath #(
    parameter int unsigned MAX_WIDTH  = dtpb_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = dtpb_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  dtpb_pkg::t_cfg                           i_cfg,
    input  dtpb_pkg::t_dp_cmd                        i_cmd,
    output dtpb_pkg::t_dp_status                     o_status,
    input  wire logic [dtpb_pkg::DEPTH_W-1:0]        i_depth_mm,
    input  wire logic                                i_frame_start,
    input  wire logic                                i_frame_end,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic [dtpb_pkg::COORD_W-1:0]             o_point_x,
    output logic [dtpb_pkg::COORD_W-1:0]             o_point_y,
    output logic [dtpb_pkg::Z_W-1:0]                 o_point_z,
    output logic                                     o_point_valid,
    output logic                                     o_frame_done
);
    import dtpb_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);

    // Position state
    logic [CW-1:0] r_column, n_column;
    logic [RW-1:0] r_row, n_row;
    logic [7:0]    r_col_phase, n_col_phase;
    logic [7:0]    r_row_phase, n_row_phase;

    // Per-item working registers
    logic [15:0]        r_depth;
    logic               r_kept;
    logic               r_end;
    logic [15:0]        r_dx, r_dy;
    logic               r_neg_x, r_neg_y;
    logic [PROD1_W-1:0] r_p1x, r_p1y;
    logic [PROD2_W-1:0] r_p2x, r_p2y;

    // Output register
    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x, r_out_y;
    logic [Z_W-1:0]     r_out_z;
    logic               r_out_pv, r_out_done;

    // Effective position and config for the incoming pixel
    logic [CW-1:0] col_eff;
    logic [RW-1:0] row_eff;
    logic [7:0]    cph_eff, rph_eff;
    logic [7:0]    step;
    logic [12:0]   width;
    logic          kept_now;
    logic [15:0]   pos_x, pos_y;
    logic          neg_x, neg_y;
    logic [15:0]   mag_x, mag_y;

    always_comb begin
        col_eff = i_frame_start ? '0 : r_column;
        row_eff = i_frame_start ? '0 : r_row;
        cph_eff = i_frame_start ? 8'd0 : r_col_phase;
        rph_eff = i_frame_start ? 8'd0 : r_row_phase;
        step    = (i_cfg.stride == 8'd0) ? 8'd1 : i_cfg.stride;
        if (i_cfg.image_width == 13'd0)                 width = 13'd1;
        else if (i_cfg.image_width > 13'(MAX_WIDTH))    width = 13'(MAX_WIDTH);
        else                                            width = i_cfg.image_width;

        kept_now = (cph_eff == 8'd0) && (rph_eff == 8'd0) && (i_depth_mm != 16'd0) &&
                   (i_depth_mm >= i_cfg.min_depth_mm) && (i_depth_mm <= i_cfg.max_depth_mm);

        // Offsets from the principal point in 1/16 pixel, as sign and magnitude
        pos_x = 16'({col_eff, 4'b0000});
        pos_y = 16'({row_eff, 4'b0000});
        neg_x = pos_x < i_cfg.center_x;
        neg_y = pos_y < i_cfg.center_y;
        mag_x = neg_x ? (i_cfg.center_x - pos_x) : (pos_x - i_cfg.center_x);
        mag_y = neg_y ? (i_cfg.center_y - pos_y) : (pos_y - i_cfg.center_y);
    end

    // Raster advance
    always_comb begin
        n_column    = col_eff;
        n_row       = row_eff;
        n_col_phase = cph_eff;
        n_row_phase = rph_eff;
        if (i_frame_end) begin
            n_column    = '0;
            n_row       = '0;
            n_col_phase = 8'd0;
            n_row_phase = 8'd0;
        end else if ((13'(col_eff) + 13'd1) >= width) begin
            n_column    = '0;
            n_col_phase = 8'd0;
            if (((RW+1)'(row_eff) + (RW+1)'(1)) >= (RW+1)'(MAX_HEIGHT)) begin
                n_row       = '0;
                n_row_phase = 8'd0;
            end else begin
                n_row       = row_eff + RW'(1);
                n_row_phase = (({1'b0, rph_eff} + 9'd1) >= {1'b0, step}) ?
                              8'd0 : (rph_eff + 8'd1);
            end
        end else begin
            n_column    = col_eff + CW'(1);
            n_col_phase = (({1'b0, cph_eff} + 9'd1) >= {1'b0, step}) ?
                          8'd0 : (cph_eff + 8'd1);
        end
    end

    // Position state update on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_row       <= '0;
            r_col_phase <= 8'd0;
            r_row_phase <= 8'd0;
        end else if (i_cmd.accept) begin
            r_column    <= n_column;
            r_row       <= n_row;
            r_col_phase <= n_col_phase;
            r_row_phase <= n_row_phase;
        end
    end

    // Item capture and multiply chain
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_depth <= i_depth_mm;
            r_kept  <= kept_now;
            r_end   <= i_frame_end;
            r_dx    <= mag_x;
            r_dy    <= mag_y;
            r_neg_x <= neg_x;
            r_neg_y <= neg_y;
        end
        if (i_cmd.mul_depth_en) begin
            r_p1x <= PROD1_W'(r_dx) * PROD1_W'(r_depth);
            r_p1y <= PROD1_W'(r_dy) * PROD1_W'(r_depth);
        end
        if (i_cmd.mul_focal_en) begin
            r_p2x <= PROD2_W'(r_p1x) * PROD2_W'(i_cfg.inv_focal_x);
            r_p2y <= PROD2_W'(r_p1y) * PROD2_W'(i_cfg.inv_focal_y);
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_x    <= r_kept ? round_sat(r_p2x, r_neg_x) : '0;
            r_out_y    <= r_kept ? round_sat(r_p2y, r_neg_y) : '0;
            r_out_z    <= r_kept ? {r_depth, 4'b0000} : '0;
            r_out_pv   <= r_kept;
            r_out_done <= r_end;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.has_result = kept_now | i_frame_end;
    assign o_status.out_free   = ~r_out_valid | i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_point_x     = r_out_x;
    assign o_point_y     = r_out_y;
    assign o_point_z     = r_out_z;
    assign o_point_valid = r_out_pv;
    assign o_frame_done  = r_out_done;

endmodule

`default_nettype wire

@@ src/dtpb_checker.sv @@
// Port-level checks for the back-projection core, bound to its top level.
`default_nettype none

module dtpb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // Reset empties the output register
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A result without a point is only the frame-end marker, with zero payload
    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 72'd0))
        else $error("empty result is not a clean frame-end marker");

    // A kept point always has a nonzero depth
    a_point_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[67:48] != 20'd0))
        else $error("kept point with zero depth");

    // A frame-end pixel always starts the multiply chain, so input closes
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still open after frame-end pixel");

endmodule

bind depth_to_point_backprojection_core dtpb_checker u_dtpb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ tb/sv/tb_depth_to_point_backprojection_core.sv @@
// Self-checking testbench for the depth-to-point back-projection core: predictor, driver, monitor.
`timescale 1ns / 100ps

module tb_depth_to_point_backprojection_core;
    import dtpb_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned RANDOM_PIXELS = 1020;
    localparam int unsigned RANDOM_SETUPS = 6;
    localparam int unsigned WIDE_FRAME    = 24;

    // One pixel item as it enters the core
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               sof;
        logic               eof;
    } t_pixel;

    // One point item as it leaves the core
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [Z_W-1:0]     z;
        logic               kept;
        logic               done;
    } t_point;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;     // [15:0] depth_mm
    logic                   s_axis_tuser  = 1'b0;   // frame_start
    logic                   s_axis_tlast  = 1'b0;   // frame_end
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;           // [23:0] point_x, [47:24] point_y,
                                                    // [67:48] point_z, [71:68] zero
    logic                   m_axis_tuser;           // point_valid
    logic                   m_axis_tlast;           // frame_done
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wr_data = '0;

    // Shadow registers and raster position of the predictor
    t_cfg        cam_cfg;
    logic [11:0] pix_col   = '0;
    logic [11:0] pix_row   = '0;
    logic [7:0]  col_phase = '0;
    logic [7:0]  row_phase = '0;

    t_pixel pending_pixels[$];
    t_point expected_points[$];

    int unsigned errors       = 0;
    int unsigned pixels_sent  = 0;
    int unsigned points_seen  = 0;
    int unsigned kept_points  = 0;
    int unsigned frames_done  = 0;
    int unsigned setups       = 0;
    int unsigned cycles       = 0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    logic        px_fire      = 1'b0;

    depth_to_point_backprojection_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Offset from principal point times depth times 1/f, rounded half away, saturated
    function automatic logic [COORD_W-1:0] scale_axis(input logic [11:0] coord,
                                                      input logic [15:0] center,
                                                      input logic [15:0] depth,
                                                      input logic [23:0] inv_f);
        logic [15:0] pos;
        logic        neg;
        logic [15:0] diff;
        logic [63:0] mag;
        pos  = {coord, 4'b0000};
        neg  = pos < center;
        diff = neg ? center - pos : pos - center;
        mag  = (64'(diff) * 64'(depth) * 64'(inv_f) + 64'(ROUND_HALF)) >> 24;
        if (neg) begin
            if (mag > 64'(NEG_LIMIT)) return 24'h800000;
            return 24'd0 - mag[23:0];
        end
        if (mag > 64'(POS_LIMIT)) return 24'h7FFFFF;
        return mag[23:0];
    endfunction

    function automatic void home_position();
        pix_col   = '0;
        pix_row   = '0;
        col_phase = '0;
        row_phase = '0;
    endfunction

    // Predict the point item (if any) for one accepted pixel and advance the raster
    function automatic void backproject_pixel(input t_pixel px);
        int unsigned row_step;
        int unsigned row_len;
        logic        kept;
        t_point      pt;
        row_step = (cam_cfg.stride == 0) ? 1 : cam_cfg.stride;
        row_len  = (cam_cfg.image_width == 0) ? 1 : cam_cfg.image_width;
        if (row_len > MAX_WIDTH_DEF) row_len = MAX_WIDTH_DEF;
        if (px.sof) home_position();

        kept = col_phase == 0 && row_phase == 0 && px.depth != 0 &&
               px.depth >= cam_cfg.min_depth_mm && px.depth <= cam_cfg.max_depth_mm;
        if (kept || px.eof) begin
            pt = '0;
            if (kept) begin
                pt.x    = scale_axis(pix_col, cam_cfg.center_x, px.depth, cam_cfg.inv_focal_x);
                pt.y    = scale_axis(pix_row, cam_cfg.center_y, px.depth, cam_cfg.inv_focal_y);
                pt.z    = {px.depth, 4'b0000};
                pt.kept = 1'b1;
            end
            pt.done = px.eof;
            expected_points = {expected_points, pt};
        end

        if (px.eof) begin
            home_position();
        end else if (pix_col + 1 >= row_len) begin
            pix_col   = '0;
            col_phase = '0;
            // row counter wraps after the last row, phase restarts too
            if (pix_row + 1 >= MAX_HEIGHT_DEF) begin
                pix_row   = '0;
                row_phase = '0;
            end else begin
                pix_row   = pix_row + 12'd1;
                row_phase = (row_phase + 1 >= row_step) ? 8'd0 : row_phase + 8'd1;
            end
        end else begin
            pix_col   = pix_col + 12'd1;
            col_phase = (col_phase + 1 >= row_step) ? 8'd0 : col_phase + 8'd1;
        end
    endfunction

    function automatic void check_field(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // Monitor on the point side, predictor on the pixel side
    always @(posedge i_clk) begin
        t_point want;
        px_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            points_seen++;
            if (expected_points.size() == 0) begin
                errors++;
                $display("%0t: unexpected point item: expected none, %s %h tuser %b tlast %b",
                         $time, "actual tdata", m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                want = expected_points.pop_front();
                if (want.kept) kept_points++;
                if (want.done) frames_done++;
                check_field("point_x", want.x, m_axis_tdata[23:0]);
                check_field("point_y", want.y, m_axis_tdata[47:24]);
                check_field("point_z", 24'(want.z), 24'(m_axis_tdata[67:48]));
                check_field("tdata pad", 24'd0, 24'(m_axis_tdata[71:68]));
                check_field("point_valid", 24'(want.kept), 24'(m_axis_tuser));
                check_field("frame_done", 24'(want.done), 24'(m_axis_tlast));
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            backproject_pixel({s_axis_tdata, s_axis_tuser, s_axis_tlast});
    end

    // Pixel driver: next item once the current one is taken, with random gaps
    always @(negedge i_clk) begin
        t_pixel px;
        if (i_rst_n && (!s_axis_tvalid || px_fire)) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                px = pending_pixels.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= px.depth;
                s_axis_tuser  <= px.sof;
                s_axis_tlast  <= px.eof;
                pixels_sent++;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Point receiver back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: run limit reached with %0d point items outstanding",
                     $time, expected_points.size());
            $display("tb_depth_to_point_backprojection_core: errors");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_index idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= val;
        case (idx)
            CFG_MIN_DEPTH:   cam_cfg.min_depth_mm = val[15:0];
            CFG_MAX_DEPTH:   cam_cfg.max_depth_mm = val[15:0];
            CFG_STRIDE:      cam_cfg.stride       = val[7:0];
            CFG_IMAGE_WIDTH: cam_cfg.image_width  = val[12:0];
            CFG_CENTER_X:    cam_cfg.center_x     = val[15:0];
            CFG_CENTER_Y:    cam_cfg.center_y     = val[15:0];
            CFG_INV_FOCAL_X: cam_cfg.inv_focal_x  = val;
            CFG_INV_FOCAL_Y: cam_cfg.inv_focal_y  = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic load_setup(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [7:0] strd, input logic [12:0] wid,
                              input logic [15:0] cx, input logic [15:0] cy,
                              input logic [23:0] fx, input logic [23:0] fy);
        write_reg(CFG_MIN_DEPTH, 24'(lo));
        write_reg(CFG_MAX_DEPTH, 24'(hi));
        write_reg(CFG_STRIDE, 24'(strd));
        write_reg(CFG_IMAGE_WIDTH, 24'(wid));
        write_reg(CFG_CENTER_X, 24'(cx));
        write_reg(CFG_CENTER_Y, 24'(cy));
        write_reg(CFG_INV_FOCAL_X, fx);
        write_reg(CFG_INV_FOCAL_Y, fy);
        setups++;
    endtask

    task automatic push(input logic [15:0] depth, input logic sof, input logic eof);
        t_pixel px;
        px = {depth, sof, eof};
        pending_pixels = {pending_pixels, px};
    endtask

    // Hold the sender until every expected point has come back, then let the core settle
    task automatic wait_drained();
        while (pending_pixels.size() != 0 || s_axis_tvalid || expected_points.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Stimulus
    initial begin
        int unsigned phase;
        int unsigned queued;
        int unsigned cols;
        int unsigned rows;
        int unsigned total;
        int unsigned shape;
        int unsigned pick;
        int unsigned n;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] d;
        logic [12:0] wid;
        logic [7:0]  strd;
        logic [23:0] fx;
        logic [23:0] fy;
        logic        sof;
        logic        eof;

        cam_cfg.min_depth_mm = RST_MIN_DEPTH;
        cam_cfg.max_depth_mm = RST_MAX_DEPTH;
        cam_cfg.stride       = RST_STRIDE;
        cam_cfg.image_width  = RST_IMAGE_WIDTH;
        cam_cfg.center_x     = RST_CENTER_X;
        cam_cfg.center_y     = RST_CENTER_Y;
        cam_cfg.inv_focal_x  = RST_INV_FOCAL_X;
        cam_cfg.inv_focal_y  = RST_INV_FOCAL_Y;
        src_idle_pct = 15;
        snk_idle_pct = 53;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: column 1 is off the default stride grid
        push(16'd1000, 1'b1, 1'b0);
        push(16'd1000, 1'b0, 1'b0);
        push(16'd1000, 1'b0, 1'b1);
        wait_drained();

        // Depth extremes, zero depth, full-scale 1/f with negative saturation on y,
        // a frame end whose pixel is not kept, and a pixel after frame end without frame start
        load_setup(16'd1, 16'hFFFF, 8'd1, 13'd3, 16'd0, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        push(16'hFFFF, 1'b1, 1'b0);
        push(16'd1, 1'b0, 1'b0);
        push(16'd0, 1'b0, 1'b0);
        push(16'hFFFF, 1'b0, 1'b0);
        push(16'd32768, 1'b0, 1'b1);
        push(16'd0, 1'b0, 1'b1);
        push(16'd300, 1'b0, 1'b0);
        wait_drained();

        // Stride zero and width zero (one pixel per row); frame left open from above
        load_setup(16'd0, 16'hFFFF, 8'd0, 13'd0, 16'hFFFF, 16'd0, 24'd0, 24'd1);
        push(16'd0, 1'b1, 1'b0);
        push(16'hFFFF, 1'b0, 1'b0);
        push(16'd2, 1'b0, 1'b0);
        push(16'd4000, 1'b0, 1'b1);
        wait_drained();

        // Minimum above maximum: only the frame end gives an item
        load_setup(16'd5000, 16'd300, 8'd1, 13'd4, 16'd0, 16'd0, 24'd43690, 24'd43690);
        push(16'd3000, 1'b1, 1'b0);
        push(16'd5000, 1'b0, 1'b0);
        push(16'd300, 1'b0, 1'b1);
        wait_drained();

        // Largest stride: only the origin pixel is on the grid
        load_setup(16'd300, 16'd5000, 8'd255, 13'd2, 16'd16, 16'd16, 24'd43690, 24'd43690);
        push(16'd1000, 1'b1, 1'b0);
        for (n = 0; n < 4; n++) push(16'd1000, 1'b0, 1'b0);
        push(16'd1000, 1'b0, 1'b1);
        wait_drained();

        // Random setups with random frames; idling swaps after two setups and stops after four
        for (phase = 0; phase < RANDOM_SETUPS; phase++) begin
            if (phase == 2) begin
                src_idle_pct = 53;
                snk_idle_pct = 15;
            end else if (phase == 4) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            lo = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(3000));
            hi = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(65535, 2000));
            if ($urandom_range(7) == 0) {lo, hi} = {hi, lo};
            pick = $urandom_range(9);
            strd = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(4, 1));
            wid  = ($urandom_range(7) == 0) ? 13'd0 : 13'($urandom_range(16, 1));
            pick = $urandom_range(3);
            fx = (pick == 0) ? 24'hFFFFFF : (pick == 1) ? 24'($urandom) :
                 24'($urandom_range(400000, 20000));
            fy = ($urandom_range(7) == 0) ? 24'd0 : 24'($urandom_range(400000, 20000));
            load_setup(lo, hi, strd, wid,
                       ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(wid * 16)),
                       ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(64)),
                       fx, fy);

            cols   = (wid == 0) ? 1 : wid;
            queued = 0;
            while (queued < RANDOM_PIXELS / RANDOM_SETUPS) begin
                rows  = $urandom_range(4, 1);
                total = cols * rows;
                // mostly clean frames; some cut short, some without start, some noise
                shape = $urandom_range(99);
                if (shape >= 75 && shape < 85) total = $urandom_range(total, 1);
                for (n = 0; n < total; n++) begin
                    pick = $urandom_range(99);
                    if (pick < 12)
                        d = 16'd0;
                    else if (pick < 30 || lo > hi)
                        d = 16'($urandom);
                    else if (pick < 36)
                        d = lo;
                    else if (pick < 42)
                        d = hi;
                    else
                        d = 16'($urandom_range(hi, lo));
                    if (shape < 90) begin
                        sof = (n == 0) && shape < 85;
                        eof = (n == total - 1) && (shape < 75 || shape >= 85);
                    end else begin
                        sof = ($urandom_range(7) == 0);
                        eof = ($urandom_range(7) == 0);
                    end
                    push(d, sof, eof);
                end
                queued += total;
            end
            wait_drained();
        end

        // Width above the maximum is clamped, so a short row never wraps
        load_setup(16'd1, 16'hFFFF, 8'd1, 13'h1FFF, 16'h8000, 16'd0,
                   24'($urandom), 24'($urandom));
        for (n = 0; n < WIDE_FRAME; n++)
            push(16'($urandom_range(65535, 1)), n == 0, n == WIDE_FRAME - 1);
        wait_drained();

        $display("Run covered %0d pixel items over %0d register setups.", pixels_sent, setups);
        $display("Checked %0d point items: %0d with a point, %0d frame ends, %0d mismatches.",
                 points_seen, kept_points, frames_done, errors);
        if (errors == 0) begin
            $display("tb_depth_to_point_backprojection_core: clean");
        end else begin
            $display("tb_depth_to_point_backprojection_core: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/dtpb_pkg.sv
src/dtpb_cfg_regs.sv
src/dtpb_ctrl.sv
src/dtpb_datapath.sv
src/depth_to_point_backprojection_core.sv
src/dtpb_checker.sv
tb/sv/tb_depth_to_point_backprojection_core.sv
